### sv/hsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, constants and the CRC-8 byte update for the humidity sensor
// reply frame decoder.
// ----------------------------------------------------------------------------
package hsfd_pkg;

  // CRC-8, polynomial x^8+x^5+x^4+1, no reflection, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Conversion scales, applied as floor(span*raw/65535) - offset
  localparam int unsigned TEMP_PROD_W = 31;  // 17500 * 65535 < 2^31
  localparam int unsigned HUM_PROD_W  = 30;  // 12500 * 65535 < 2^30
  localparam int unsigned RAW_W       = 16;
  localparam int unsigned TEMP_W      = 15;
  localparam int unsigned HUM_W       = 14;
  localparam int unsigned SERIAL_W    = 32;

  localparam logic [TEMP_PROD_W-1:0] TEMP_SPAN   = TEMP_PROD_W'(17500);
  localparam logic [HUM_PROD_W-1:0]  HUM_SPAN    = HUM_PROD_W'(12500);
  localparam logic [TEMP_W:0]        TEMP_OFFSET = (TEMP_W + 1)'(4500);
  localparam logic [HUM_W-1:0]       HUM_OFFSET  = HUM_W'(600);
  localparam logic [HUM_W-1:0]       HUM_MAX     = HUM_W'(10000);

  // Config register map
  localparam int unsigned APB_ADDR_W     = 3;
  localparam logic        REG_FRAME_KIND = 1'b0;  // word index

  typedef enum logic {
    KIND_MEASURE = 1'b0,
    KIND_SERIAL  = 1'b1
  } frame_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CRC_WORD0 = 2'd1,
    STATUS_CRC_WORD1 = 2'd2
  } status_t;

  // Position of the next byte within a reply
  typedef enum logic [2:0] {
    POS_HI0  = 3'd0,
    POS_LO0  = 3'd1,
    POS_CRC0 = 3'd2,
    POS_HI1  = 3'd3,
    POS_LO1  = 3'd4,
    POS_CRC1 = 3'd5
  } pos_t;

  // Collected reply, handed to the result stage on the last byte
  typedef struct packed {
    logic                   fire;      // last byte accepted this cycle
    logic                   bad0;      // word 0 CRC mismatch
    logic                   bad1;      // word 1 CRC mismatch
    logic [RAW_W-1:0]       w0;
    logic [RAW_W-1:0]       w1;
    logic [TEMP_PROD_W-1:0] temp_prod;
    logic [HUM_PROD_W-1:0]  hum_prod;
  } frame_t;

  // One byte through the CRC-8 shift register, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### sv/humidity_sensor_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder
// Decodes six-byte sensor replies: CRC-8 check per word, then temperature and
// humidity in hundredths, or a 32-bit serial number.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained; bytes keep flowing while a
//   result waits in the output register; only the sixth byte of the next
//   reply is held off until that result is taken.
// Timing: the result beat is valid in the cycle after the sixth byte's beat;
//   each word's scale multiply runs on the beat that completes the word.
// Reset (rst, synchronous): byte position to 0, output empty, frame_kind to
//   measurement. Stored reply bytes are not cleared.
module humidity_sensor_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  // input bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] rx_byte
  input  logic        s_tuser,    // [0] frame_start
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,    // [1:0] status, [16:2] temperature_centi,
                                  // [30:17] humidity_centi, [62:31] serial_number
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [hsfd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hsfd_pkg::frame_kind_t frame_kind;
  hsfd_pkg::frame_t      frm;
  hsfd_pkg::status_t     status;

  logic                                 in_beat;
  logic                                 in_room;
  logic                                 at_last;
  logic                                 reg_sel;
  logic signed [hsfd_pkg::TEMP_W-1:0]   temperature_centi;
  logic [hsfd_pkg::HUM_W-1:0]           humidity_centi;
  logic [hsfd_pkg::SERIAL_W-1:0]        serial_number;

  // Config register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == hsfd_pkg::REG_FRAME_KIND);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind <= hsfd_pkg::KIND_MEASURE;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      frame_kind <= hsfd_pkg::frame_kind_t'(pwdata[0]);
    end
  end

  assign prdata = reg_sel ? {31'd0, frame_kind} : 32'd0;

  // Input handshake: only a byte that can complete a reply needs room
  assign s_tready = in_room || !at_last;
  assign in_beat  = s_tvalid && s_tready;

  hsfd_collect u_collect (
    .clk         (clk),
    .rst         (rst),
    .beat        (in_beat),
    .rx_byte     (s_tdata),
    .frame_start (s_tuser),
    .at_last     (at_last),
    .frm         (frm)
  );

  hsfd_result u_result (
    .clk               (clk),
    .rst               (rst),
    .frm               (frm),
    .frame_kind        (frame_kind),
    .out_ready         (m_tready),
    .out_valid         (m_tvalid),
    .in_room           (in_room),
    .status            (status),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .serial_number     (serial_number)
  );

  assign m_tdata = {1'b0, serial_number, humidity_centi, temperature_centi, status};

  // Checks
  a_fire_loads: assert property (@(posedge clk) disable iff (rst)
    frm.fire |=> m_tvalid)
    else $error("result beat missing after last byte");

  a_taken_clears: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !frm.fire) |=> !m_tvalid)
    else $error("result beat repeated");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status != hsfd_pkg::STATUS_OK) |-> (m_tdata[62:2] == 61'd0))
    else $error("value fields not zero on CRC error");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (humidity_centi <= hsfd_pkg::HUM_MAX))
    else $error("humidity out of clamp range");

endmodule

### sv/hsfd_collect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_collect
// Tracks the byte position, runs the CRC per word, keeps the reply words and
// starts the scale multiplies as soon as each word is complete.
// ----------------------------------------------------------------------------
module hsfd_collect (
  input  logic                clk,
  input  logic                rst,
  input  logic                beat,        // input beat accepted
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  output logic                at_last,     // next byte is the sixth of a reply
  output hsfd_pkg::frame_t    frm
);

  hsfd_pkg::pos_t pos;
  hsfd_pkg::pos_t pos_eff;
  hsfd_pkg::pos_t pos_next;

  logic [7:0]                      crc;
  logic [7:0]                      hi0;
  logic [7:0]                      hi1;
  logic [hsfd_pkg::RAW_W-1:0]      w0;
  logic [hsfd_pkg::RAW_W-1:0]      w1;
  logic                            bad0;
  logic [hsfd_pkg::TEMP_PROD_W-1:0] temp_prod;
  logic [hsfd_pkg::HUM_PROD_W-1:0]  hum_prod;
  logic [hsfd_pkg::RAW_W-1:0]      word_in0;
  logic [hsfd_pkg::RAW_W-1:0]      word_in1;

  // A start mark, or a position out of range, restarts at byte 0
  assign pos_eff = (frame_start || pos > hsfd_pkg::POS_CRC1) ? hsfd_pkg::POS_HI0 : pos;

  // Only a beat taken here can produce a result
  assign at_last = (pos == hsfd_pkg::POS_CRC1);

  assign word_in0 = {hi0, rx_byte};
  assign word_in1 = {hi1, rx_byte};

  // Next position
  always_comb begin
    pos_next = pos;
    if (beat) begin
      case (pos_eff)
        hsfd_pkg::POS_HI0:  pos_next = hsfd_pkg::POS_LO0;
        hsfd_pkg::POS_LO0:  pos_next = hsfd_pkg::POS_CRC0;
        hsfd_pkg::POS_CRC0: pos_next = hsfd_pkg::POS_HI1;
        hsfd_pkg::POS_HI1:  pos_next = hsfd_pkg::POS_LO1;
        hsfd_pkg::POS_LO1:  pos_next = hsfd_pkg::POS_CRC1;
        default:            pos_next = hsfd_pkg::POS_HI0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= hsfd_pkg::POS_HI0;
    end else begin
      pos <= pos_next;
    end
  end

  // Byte capture, CRC and scale products
  always_ff @(posedge clk) begin
    if (beat) begin
      case (pos_eff)
        hsfd_pkg::POS_HI0: begin
          hi0 <= rx_byte;
          crc <= hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, rx_byte);
        end
        hsfd_pkg::POS_LO0: begin
          w0        <= word_in0;
          crc       <= hsfd_pkg::crc8_byte(crc, rx_byte);
          temp_prod <= hsfd_pkg::TEMP_SPAN * hsfd_pkg::TEMP_PROD_W'(word_in0);
        end
        hsfd_pkg::POS_CRC0: begin
          bad0 <= (crc != rx_byte);
        end
        hsfd_pkg::POS_HI1: begin
          hi1 <= rx_byte;
          crc <= hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, rx_byte);
        end
        hsfd_pkg::POS_LO1: begin
          w1       <= word_in1;
          crc      <= hsfd_pkg::crc8_byte(crc, rx_byte);
          hum_prod <= hsfd_pkg::HUM_SPAN * hsfd_pkg::HUM_PROD_W'(word_in1);
        end
        default: begin
          // last byte: checked combinationally below
        end
      endcase
    end
  end

  // Hand-off on the last byte
  always_comb begin
    frm.fire      = beat && (pos_eff == hsfd_pkg::POS_CRC1);
    frm.bad0      = bad0;
    frm.bad1      = (crc != rx_byte);
    frm.w0        = w0;
    frm.w1        = w1;
    frm.temp_prod = temp_prod;
    frm.hum_prod  = hum_prod;
  end

endmodule

### sv/hsfd_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfd_result
// Finishes the conversion (divide by 65535, offset, clamp), picks the status
// and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module hsfd_result (
  input  logic                                clk,
  input  logic                                rst,
  input  hsfd_pkg::frame_t                    frm,
  input  hsfd_pkg::frame_kind_t               frame_kind,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                in_room,
  output hsfd_pkg::status_t                   status,
  output logic signed [hsfd_pkg::TEMP_W-1:0]  temperature_centi,
  output logic [hsfd_pkg::HUM_W-1:0]          humidity_centi,
  output logic [hsfd_pkg::SERIAL_W-1:0]       serial_number
);

  logic [hsfd_pkg::TEMP_PROD_W-1:0] tsum;
  logic [hsfd_pkg::HUM_PROD_W-1:0]  hsum;
  logic [hsfd_pkg::TEMP_W-1:0]      tq;
  logic [hsfd_pkg::HUM_W-1:0]       hq;
  logic [hsfd_pkg::TEMP_W:0]        tdiff;
  logic [hsfd_pkg::HUM_W-1:0]       hclamp;

  hsfd_pkg::status_t                    status_next;
  logic [hsfd_pkg::TEMP_W-1:0]          temp_next;
  logic [hsfd_pkg::HUM_W-1:0]           hum_next;
  logic [hsfd_pkg::SERIAL_W-1:0]        serial_next;

  // floor(p/65535) = (p + (p>>16) + 1) >> 16, exact while the quotient < 2^16
  assign tsum = frm.temp_prod + (frm.temp_prod >> 16) + hsfd_pkg::TEMP_PROD_W'(1);
  assign hsum = frm.hum_prod + (frm.hum_prod >> 16) + hsfd_pkg::HUM_PROD_W'(1);
  assign tq   = tsum[16 +: hsfd_pkg::TEMP_W];
  assign hq   = hsum[16 +: hsfd_pkg::HUM_W];

  assign tdiff = {1'b0, tq} - hsfd_pkg::TEMP_OFFSET;

  // Humidity offset with clamp to 0..10000
  always_comb begin
    if (hq < hsfd_pkg::HUM_OFFSET) begin
      hclamp = '0;
    end else if (hq - hsfd_pkg::HUM_OFFSET > hsfd_pkg::HUM_MAX) begin
      hclamp = hsfd_pkg::HUM_MAX;
    end else begin
      hclamp = hq - hsfd_pkg::HUM_OFFSET;
    end
  end

  // Status priority and field selection
  always_comb begin
    status_next = hsfd_pkg::STATUS_OK;
    temp_next   = '0;
    hum_next    = '0;
    serial_next = '0;
    if (frm.bad0) begin
      status_next = hsfd_pkg::STATUS_CRC_WORD0;
    end else if (frm.bad1) begin
      status_next = hsfd_pkg::STATUS_CRC_WORD1;
    end else if (frame_kind == hsfd_pkg::KIND_MEASURE) begin
      temp_next = tdiff[hsfd_pkg::TEMP_W-1:0];
      hum_next  = hclamp;
    end else begin
      serial_next = {frm.w0, frm.w1};
    end
  end

  // Output register
  assign in_room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frm.fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frm.fire) begin
      status            <= status_next;
      temperature_centi <= temp_next;
      humidity_centi    <= hum_next;
      serial_number     <= serial_next;
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for humidity_sensor_frame_decoder. A byte stream of
// sensor replies (well-formed frames with good and corrupted CRCs, partial
// frames, unmarked starts and noise) is driven in random bursts. A local
// decoder predicts each status, temperature, humidity and serial result,
// and the result stream is checked field by field under random stalls.
// frame_kind is switched over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import hsfd_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 4;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_ITEMS    = 190;
  localparam int REG_UNUSED_IDX = 1;

  // conversion constants, hundredths
  localparam int T_SCALE  = 17500;
  localparam int T_OFFS   = 4500;
  localparam int H_SCALE  = 12500;
  localparam int H_OFFS   = 600;
  localparam int H_TOP    = 10000;
  localparam int RAW_SPAN = 65535;

  // CRC corruption selectors for generated frames
  localparam int CORRUPT_NONE = 0;
  localparam int CORRUPT_W0   = 1;
  localparam int CORRUPT_W1   = 2;
  localparam int CORRUPT_BOTH = 3;

  typedef struct {
    logic [7:0] data;
    logic       mark;
  } reply_beat_t;

  typedef struct {
    status_t     status;
    logic [14:0] temp;
    logic [13:0] hum;
    logic [31:0] serial;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
  logic        s_tuser = 1'b0;    // [0] frame_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;           // [1:0] status, [16:2] temperature_centi,
                                  // [30:17] humidity_centi, [62:31] serial_number
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  reply_beat_t byte_queue[$];
  decoded_t    decoded_expected[$];

  // decoder shadow state
  frame_kind_t kind_shadow = KIND_MEASURE;
  int          rx_pos = 0;
  logic [7:0]  rx_buf[5];

  int errors = 0;
  int beats_pushed = 0;
  int beats_accepted = 0;
  int replies_checked = 0;
  int status_count[3] = '{0, 0, 0};
  int serial_replies = 0;
  int kind_writes = 0;
  int idle_cycles = 0;

  // driver pacing
  int burst_left = 0;
  int gap_left = 0;
  // receiver stall pattern
  logic [7:0] stall_pat = 8'hFF;
  int pat_age = 0;

  humidity_sensor_frame_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // CRC-8 over one 16-bit word, bit-serial, MSB first
  function automatic logic [7:0] word_crc(input logic [15:0] w);
    logic [7:0] r;
    logic fb;
    r = CRC_INIT;
    for (int i = 15; i >= 0; i--) begin
      fb = r[7] ^ w[i];
      r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // raw word biased toward the humidity clamp regions now and then
  function automatic logic [15:0] pick_raw();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      return 16'($urandom_range(0, 3500));
    end else if (sel == 1) begin
      return 16'($urandom_range(56000, 65535));
    end
    return 16'($urandom);
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    errors++;
  endtask

  // Predict the block's response to one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic mark);
    int pos;
    int t;
    int h;
    logic [15:0] w0;
    logic [15:0] w1;
    decoded_t d;
    pos = rx_pos;
    if (mark || pos > 5) pos = 0;
    if (pos < 5) begin
      rx_buf[pos] = b;
      rx_pos = pos + 1;
    end else begin
      rx_pos = 0;
      w0 = {rx_buf[0], rx_buf[1]};
      w1 = {rx_buf[3], rx_buf[4]};
      d.status = STATUS_OK;
      d.temp = '0;
      d.hum = '0;
      d.serial = '0;
      if (word_crc(w0) != rx_buf[2]) begin
        d.status = STATUS_CRC_WORD0;
      end else if (word_crc(w1) != b) begin
        d.status = STATUS_CRC_WORD1;
      end else if (kind_shadow == KIND_MEASURE) begin
        t = (T_SCALE * int'(w0)) / RAW_SPAN - T_OFFS;
        h = (H_SCALE * int'(w1)) / RAW_SPAN - H_OFFS;
        if (h < 0) h = 0;
        if (h > H_TOP) h = H_TOP;
        d.temp = t[14:0];
        d.hum = h[13:0];
      end else begin
        d.serial = {w0, w1};
      end
      decoded_expected.push_back(d);
    end
  endtask

  task automatic push_beat(input logic [7:0] b, input logic mark);
    reply_beat_t nb;
    nb.data = b;
    nb.mark = mark;
    byte_queue.push_back(nb);
    beats_pushed++;
  endtask

  // Queue a six-byte reply, optionally with broken CRC bytes
  task automatic push_frame(input logic [15:0] w0, input logic [15:0] w1, input logic mark,
                            input int corrupt);
    logic [7:0] c0;
    logic [7:0] c1;
    c0 = word_crc(w0);
    c1 = word_crc(w1);
    if (corrupt & CORRUPT_W0) c0 ^= 8'($urandom_range(1, 255));
    if (corrupt & CORRUPT_W1) c1 ^= 8'($urandom_range(1, 255));
    push_beat(w0[15:8], mark);
    push_beat(w0[7:0], 1'b0);
    push_beat(c0, 1'b0);
    push_beat(w1[15:8], 1'b0);
    push_beat(w1[7:0], 1'b0);
    push_beat(c1, 1'b0);
  endtask

  // APB write: setup, access, done on the edge with pready high
  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if ((addr >> 2) == APB_ADDR_W'(REG_FRAME_KIND)) begin
      kind_shadow = frame_kind_t'(data[0]);
      kind_writes++;
    end
  endtask

  // Wait for every queued byte and every predicted result, then settle
  task automatic wait_idle();
    do @(posedge clk);
    while (beats_accepted != beats_pushed || decoded_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Byte driver: bursts of random length with random gaps
  always @(posedge clk) begin
    reply_beat_t nb;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        nb = byte_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nb.data;
        s_tuser  <= nb.mark;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 24);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            3, 4, 5, 6, 7: gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(5, 25);
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: rotating stall pattern, reloaded now and then
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        if (stall_pat == 8'h00) stall_pat = 8'h80;
        pat_age = $urandom_range(20, 80);
      end else begin
        pat_age--;
      end
      m_tready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[7:1]};
    end
  end

  // Monitor: predict on byte beats, check on result beats
  always @(posedge clk) begin
    decoded_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tuser);
        beats_accepted++;
      end
      if (m_tvalid && m_tready) begin
        if (decoded_expected.size() == 0) begin
          report("result beat with nothing expected", m_tdata[31:0], 32'h0);
        end else begin
          want = decoded_expected.pop_front();
          if (m_tdata[1:0] !== want.status)
            report("status", 32'(m_tdata[1:0]), 32'(want.status));
          if (m_tdata[16:2] !== want.temp)
            report("temperature_centi", 32'(m_tdata[16:2]), 32'(want.temp));
          if (m_tdata[30:17] !== want.hum)
            report("humidity_centi", 32'(m_tdata[30:17]), 32'(want.hum));
          if (m_tdata[62:31] !== want.serial)
            report("serial_number", m_tdata[62:31], want.serial);
          if (m_tdata[63] !== 1'b0)
            report("tdata padding", 32'(m_tdata[63]), 32'h0);
          replies_checked++;
          status_count[want.status]++;
          if (want.status == STATUS_OK && kind_shadow == KIND_SERIAL) serial_replies++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    int count;
    int noise_len;
    int corrupt;
    frame_kind_t phase_kind;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // measurement mode: extremes, dropped partial, unmarked start, CRC errors
    write_reg(APB_ADDR_W'(0), 32'h0);
    push_frame(16'h0000, 16'h0000, 1'b1, CORRUPT_NONE);
    push_beat(8'hA5, 1'b1);
    push_beat(8'h5A, 1'b0);
    push_frame(16'hFFFF, 16'hFFFF, 1'b1, CORRUPT_NONE);
    push_frame(16'h1234, 16'hBEEF, 1'b0, CORRUPT_W0);
    push_frame(16'h8000, 16'h4000, 1'b1, CORRUPT_W1);
    push_frame(16'h6666, 16'h9999, 1'b1, CORRUPT_BOTH);
    wait_idle();

    // unused register index is ignored, only bit 0 of the data counts
    write_reg(APB_ADDR_W'(REG_UNUSED_IDX * 4), 32'h1);
    write_reg(APB_ADDR_W'(0), 32'hFFFF_FFFE);
    push_frame(16'h0C4A, 16'hDEAD, 1'b1, CORRUPT_NONE);
    wait_idle();

    // serial mode
    write_reg(APB_ADDR_W'(0), 32'hFFFF_FFFF);
    push_frame(16'hFFFF, 16'hFFFF, 1'b1, CORRUPT_NONE);
    push_frame(16'h0000, 16'h0001, 1'b0, CORRUPT_NONE);
    wait_idle();

    // random phases, alternating mode
    for (int p = 0; p < 6; p++) begin
      phase_kind = frame_kind_t'(p % 2 == 0);
      if ($urandom_range(0, 1)) write_reg(APB_ADDR_W'(REG_UNUSED_IDX * 4), $urandom);
      write_reg(APB_ADDR_W'(0), ($urandom & 32'hFFFF_FFFE) | 32'(phase_kind));
      count = 0;
      while (count < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          case ($urandom_range(0, 9))
            7: corrupt = CORRUPT_W0;
            8: corrupt = CORRUPT_W1;
            9: corrupt = CORRUPT_BOTH;
            default: corrupt = CORRUPT_NONE;
          endcase
          push_frame(pick_raw(), pick_raw(), $urandom_range(0, 5) != 0, corrupt);
          count += 6;
        end else begin
          // noise: random bytes with random start marks
          noise_len = $urandom_range(1, 5);
          for (int n = 0; n < noise_len; n++) begin
            push_beat(8'($urandom), 1'($urandom));
          end
          count += noise_len;
        end
      end
      wait_idle();
    end

    $display("Decoded %0d replies from %0d bytes: %0d ok, %0d word0 CRC, %0d word1 CRC",
             replies_checked, beats_accepted, status_count[0], status_count[1],
             status_count[2]);
    $display("frame_kind written %0d times; %0d good serial replies among them",
             kind_writes, serial_replies);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
sv/hsfd_pkg.sv
sv/hsfd_collect.sv
sv/hsfd_result.sv
sv/humidity_sensor_frame_decoder.sv
bench/tb.sv
